[rtl/lsf_pkg.sv]
// Shared constants, payload types and job record of the least-squares line fit.
`timescale 1ns / 1ps
`default_nettype none

package lsf_pkg;

   localparam int MAX_SAMPLES = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;

   localparam int IN_W       = 16;
   localparam int OUT_W      = 48;
   localparam int PAIR_CNT_W = 13;

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SQ_W   = 2 * SAMPLE_BITS;
   localparam int SX_W   = SAMPLE_BITS + CNT_W;
   localparam int SXX_W  = 2 * SAMPLE_BITS + CNT_W - 1;
   localparam int PROD_W = SX_W + SXX_W;
   localparam int WIDE_W = PROD_W + 2;

   localparam int CHUNK_W     = 16;
   localparam int B_CHUNKS    = (SXX_W + CHUNK_W - 1) / CHUNK_W;
   localparam int BPAD_W      = B_CHUNKS * CHUNK_W;
   localparam int CHUNK_CNT_W = $clog2(B_CHUNKS + 1);
   localparam int PART_W      = SX_W + CHUNK_W;

   localparam int N_PRODUCTS = 6;
   localparam int PIDX_W     = $clog2(N_PRODUCTS);

   localparam int DIVN_W    = WIDE_W + FRAC_BITS + 2;
   localparam int DIVD_W    = WIDE_W + 1;
   localparam int DIV_CNT_W = $clog2(DIVN_W + 1);

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int FILL_W  = Q_PTR_W + 1;

   localparam logic [DIVN_W-1:0] POS_LIMIT = DIVN_W'((64'd1 << (OUT_W - 1)) - 64'd1);
   localparam logic [DIVN_W-1:0] NEG_LIMIT = DIVN_W'(64'd1 << (OUT_W - 1));

   typedef struct packed {
      logic signed [IN_W-1:0] x_sample;
      logic signed [IN_W-1:0] y_sample;
      logic                   last_pair;
   } pair_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] slope;
      logic signed [OUT_W-1:0] intercept;
      logic                    degenerate;
      logic [PAIR_CNT_W-1:0]   pair_count;
      logic                    overflowed;
   } fit_type;

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [SX_W-1:0]  sum_x;
      logic signed [SX_W-1:0]  sum_y;
      logic signed [SXX_W-1:0] sum_xx;
      logic signed [SXX_W-1:0] sum_xy;
      logic                    dropped;
   } job_type;

endpackage

`default_nettype wire

[rtl/lsf_front.sv]
// Front end: forms x*x and x*y of the incoming pair, accumulates run sums and hands a job off on the last pair.
`timescale 1ns / 1ps
`default_nettype none

module lsf_front import lsf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  pair_type req_pair,
   output logic     push_valid,
   output job_type  push_job,
   input  logic     push_ready
);

   logic                    s1_valid_ff;
   logic                    s1_last_ff;
   logic signed [SAMPLE_BITS-1:0] s1_x_ff;
   logic signed [SAMPLE_BITS-1:0] s1_y_ff;
   logic signed [SQ_W-1:0]  s1_xx_ff;
   logic signed [SQ_W-1:0]  s1_xy_ff;

   logic [CNT_W-1:0]        count_ff;
   logic signed [SX_W-1:0]  sum_x_ff;
   logic signed [SX_W-1:0]  sum_y_ff;
   logic signed [SXX_W-1:0] sum_xx_ff;
   logic signed [SXX_W-1:0] sum_xy_ff;
   logic                    drop_ff;

   logic                    hold;
   logic                    consume;
   logic                    room;
   logic signed [SAMPLE_BITS-1:0] x_in;
   logic signed [SAMPLE_BITS-1:0] y_in;
   job_type                 acc_in;

   assign x_in      = req_pair.x_sample[SAMPLE_BITS-1:0];
   assign y_in      = req_pair.y_sample[SAMPLE_BITS-1:0];
   assign hold      = s1_valid_ff && s1_last_ff && !push_ready;
   assign req_stall = hold;
   assign consume   = s1_valid_ff && !hold;
   assign room      = count_ff < CNT_W'(MAX_SAMPLES);

   always_comb begin
      acc_in.count   = count_ff;
      acc_in.sum_x   = sum_x_ff;
      acc_in.sum_y   = sum_y_ff;
      acc_in.sum_xx  = sum_xx_ff;
      acc_in.sum_xy  = sum_xy_ff;
      acc_in.dropped = drop_ff;
      if (room) begin
         acc_in.count  = count_ff + CNT_W'(1);
         acc_in.sum_x  = sum_x_ff + SX_W'(s1_x_ff);
         acc_in.sum_y  = sum_y_ff + SX_W'(s1_y_ff);
         acc_in.sum_xx = sum_xx_ff + SXX_W'(s1_xx_ff);
         acc_in.sum_xy = sum_xy_ff + SXX_W'(s1_xy_ff);
      end else begin
         acc_in.dropped = 1'b1;
      end
   end

   assign push_valid = consume && s1_last_ff;
   assign push_job   = acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else if (!hold) begin
         s1_valid_ff <= req_valid;
         s1_last_ff  <= req_pair.last_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         s1_x_ff  <= x_in;
         s1_y_ff  <= y_in;
         s1_xx_ff <= SQ_W'(x_in) * SQ_W'(x_in);
         s1_xy_ff <= SQ_W'(x_in) * SQ_W'(y_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_xx_ff <= '0;
         sum_xy_ff <= '0;
         drop_ff   <= 1'b0;
      end else if (consume) begin
         if (s1_last_ff) begin
            count_ff  <= '0;
            sum_x_ff  <= '0;
            sum_y_ff  <= '0;
            sum_xx_ff <= '0;
            sum_xy_ff <= '0;
            drop_ff   <= 1'b0;
         end else begin
            count_ff  <= acc_in.count;
            sum_x_ff  <= acc_in.sum_x;
            sum_y_ff  <= acc_in.sum_y;
            sum_xx_ff <= acc_in.sum_xx;
            sum_xy_ff <= acc_in.sum_xy;
            drop_ff   <= acc_in.dropped;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/lsf_queue.sv]
// Short job queue between the accumulating front end and the solver.
`timescale 1ns / 1ps
`default_nettype none

module lsf_queue import lsf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    push_ready,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type            job_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;

   assign push_ready = fill_ff != FILL_W'(Q_DEPTH);
   assign head_valid = fill_ff != '0;
   assign head_job   = job_ff[rd_ptr_ff];
   assign fill_in    = fill_ff + FILL_W'(push_valid) - FILL_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         job_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

[rtl/lsf_solve.sv]
// Back end: forms the fit determinants with a chunked multiplier and divides bit-serially.
`timescale 1ns / 1ps
`default_nettype none

module lsf_solve import lsf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output fit_type rsp_fit
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_SETUP,
      ST_MUL_RUN,
      ST_MUL_ACC,
      ST_CHECK,
      ST_DIV_LOAD,
      ST_DIV_PREP,
      ST_DIV_RUN,
      ST_DIV_SAT,
      ST_DIV_STORE,
      ST_FINISH
   } state_type;

   state_type               state_ff;
   job_type                 job_ff;
   logic [PIDX_W-1:0]       prod_idx_ff;
   logic [CHUNK_CNT_W-1:0]  chunk_cnt_ff;
   logic [SX_W-1:0]         a_mag_ff;
   logic [BPAD_W-1:0]       b_sh_ff;
   logic                    prod_neg_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic signed [WIDE_W-1:0] den_ff;
   logic signed [WIDE_W-1:0] numm_ff;
   logic signed [WIDE_W-1:0] numq_ff;
   logic [WIDE_W-1:0]       dmag_ff;
   logic                    dneg_ff;
   logic                    deg_ff;
   logic                    div_sel_ff;
   logic [WIDE_W-1:0]       nmag_ff;
   logic                    qneg_ff;
   logic [DIVN_W-1:0]       quo_ff;
   logic [DIVD_W-1:0]       rem_ff;
   logic [DIV_CNT_W-1:0]    div_cnt_ff;
   logic [OUT_W-1:0]        mag_ff;
   logic [OUT_W-1:0]        slope_ff;
   logic [OUT_W-1:0]        icpt_ff;
   logic                    rsp_valid_ff;
   fit_type                 rsp_fit_ff;

   logic signed [SX_W-1:0]  a_sel;
   logic signed [SXX_W-1:0] b_sel;
   logic [SX_W-1:0]         a_mag_in;
   logic [SXX_W-1:0]        b_mag;
   logic [PART_W-1:0]       partial;
   logic [PROD_W-1:0]       prod_in;
   logic signed [WIDE_W-1:0] prod_wide;
   logic signed [WIDE_W-1:0] term_base;
   logic signed [WIDE_W-1:0] term_in;
   logic                    term_sub;
   logic signed [WIDE_W-1:0] num_sel;
   logic [WIDE_W-1:0]       nmag_in;
   logic [WIDE_W-1:0]       dmag_in;
   logic [DIVD_W-1:0]       divisor;
   logic [DIVD_W:0]         shifted;
   logic                    q_bit;
   logic [DIVD_W-1:0]       rem_in;
   logic [DIVN_W-1:0]       quo_in;
   logic [DIVN_W-1:0]       limit;
   logic [OUT_W-1:0]        mag_in;
   logic [OUT_W-1:0]        signed_in;
   logic                    out_free;

   always_comb begin
      case (prod_idx_ff)
         PIDX_W'(0): begin
            a_sel = SX_W'(signed'({1'b0, job_ff.count}));
            b_sel = job_ff.sum_xx;
         end
         PIDX_W'(1): begin
            a_sel = job_ff.sum_x;
            b_sel = SXX_W'(job_ff.sum_x);
         end
         PIDX_W'(2): begin
            a_sel = SX_W'(signed'({1'b0, job_ff.count}));
            b_sel = job_ff.sum_xy;
         end
         PIDX_W'(3): begin
            a_sel = job_ff.sum_x;
            b_sel = SXX_W'(job_ff.sum_y);
         end
         PIDX_W'(4): begin
            a_sel = job_ff.sum_y;
            b_sel = job_ff.sum_xx;
         end
         PIDX_W'(5): begin
            a_sel = job_ff.sum_x;
            b_sel = job_ff.sum_xy;
         end
         default: begin
            a_sel = '0;
            b_sel = '0;
         end
      endcase
      a_mag_in = a_sel[SX_W-1] ? SX_W'(-a_sel) : SX_W'(a_sel);
      b_mag    = b_sel[SXX_W-1] ? SXX_W'(-b_sel) : SXX_W'(b_sel);
   end

   assign partial = a_mag_ff * b_sh_ff[BPAD_W-1 -: CHUNK_W];
   assign prod_in = (prod_ff << CHUNK_W) + PROD_W'(partial);

   always_comb begin
      prod_wide = signed'(WIDE_W'(prod_ff));
      case (prod_idx_ff[PIDX_W-1:1])
         2'd0:    term_base = den_ff;
         2'd1:    term_base = numm_ff;
         2'd2:    term_base = numq_ff;
         default: term_base = '0;
      endcase
      if (!prod_idx_ff[0]) begin
         term_base = '0;
      end
      term_sub = prod_neg_ff ^ prod_idx_ff[0];
      term_in  = term_sub ? term_base - prod_wide : term_base + prod_wide;
   end

   always_comb begin
      num_sel = div_sel_ff ? numq_ff : numm_ff;
      nmag_in = num_sel[WIDE_W-1] ? WIDE_W'(-num_sel) : WIDE_W'(num_sel);
      dmag_in = den_ff[WIDE_W-1] ? WIDE_W'(-den_ff) : WIDE_W'(den_ff);
   end

   always_comb begin
      divisor = {dmag_ff, 1'b0};
      shifted = {rem_ff, quo_ff[DIVN_W-1]};
      q_bit   = shifted >= {1'b0, divisor};
      rem_in  = q_bit ? DIVD_W'(shifted - {1'b0, divisor}) : shifted[DIVD_W-1:0];
      quo_in  = {quo_ff[DIVN_W-2:0], q_bit};
   end

   always_comb begin
      limit     = qneg_ff ? NEG_LIMIT : POS_LIMIT;
      mag_in    = (quo_ff > limit) ? limit[OUT_W-1:0] : quo_ff[OUT_W-1:0];
      signed_in = qneg_ff ? OUT_W'(-mag_ff) : mag_ff;
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE) && head_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_fit   = rsp_fit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (head_valid) begin
                  job_ff      <= head_job;
                  prod_idx_ff <= '0;
                  state_ff    <= ST_MUL_SETUP;
               end
            end
            ST_MUL_SETUP: begin
               a_mag_ff     <= a_mag_in;
               b_sh_ff      <= BPAD_W'(b_mag);
               prod_neg_ff  <= a_sel[SX_W-1] ^ b_sel[SXX_W-1];
               prod_ff      <= '0;
               chunk_cnt_ff <= '0;
               state_ff     <= ST_MUL_RUN;
            end
            ST_MUL_RUN: begin
               prod_ff      <= prod_in;
               b_sh_ff      <= b_sh_ff << CHUNK_W;
               chunk_cnt_ff <= chunk_cnt_ff + CHUNK_CNT_W'(1);
               if (chunk_cnt_ff == CHUNK_CNT_W'(B_CHUNKS - 1)) begin
                  state_ff <= ST_MUL_ACC;
               end
            end
            ST_MUL_ACC: begin
               case (prod_idx_ff[PIDX_W-1:1])
                  2'd0:    den_ff  <= term_in;
                  2'd1:    numm_ff <= term_in;
                  default: numq_ff <= term_in;
               endcase
               if (prod_idx_ff == PIDX_W'(N_PRODUCTS - 1)) begin
                  state_ff <= ST_CHECK;
               end else begin
                  prod_idx_ff <= prod_idx_ff + PIDX_W'(1);
                  state_ff    <= ST_MUL_SETUP;
               end
            end
            ST_CHECK: begin
               deg_ff     <= den_ff == '0;
               dmag_ff    <= dmag_in;
               dneg_ff    <= den_ff[WIDE_W-1];
               div_sel_ff <= 1'b0;
               if (den_ff == '0) begin
                  slope_ff <= '0;
                  icpt_ff  <= '0;
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_DIV_LOAD;
               end
            end
            ST_DIV_LOAD: begin
               nmag_ff  <= nmag_in;
               qneg_ff  <= num_sel[WIDE_W-1] ^ dneg_ff;
               state_ff <= ST_DIV_PREP;
            end
            ST_DIV_PREP: begin
               quo_ff     <= (DIVN_W'(nmag_ff) << (FRAC_BITS + 1)) + DIVN_W'(dmag_ff);
               rem_ff     <= '0;
               div_cnt_ff <= '0;
               state_ff   <= ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
               quo_ff     <= quo_in;
               rem_ff     <= rem_in;
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(DIVN_W - 1)) begin
                  state_ff <= ST_DIV_SAT;
               end
            end
            ST_DIV_SAT: begin
               mag_ff   <= mag_in;
               state_ff <= ST_DIV_STORE;
            end
            ST_DIV_STORE: begin
               if (!div_sel_ff) begin
                  slope_ff   <= signed_in;
                  div_sel_ff <= 1'b1;
                  state_ff   <= ST_DIV_LOAD;
               end else begin
                  icpt_ff  <= signed_in;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_fit_ff.slope      <= slope_ff;
                  rsp_fit_ff.intercept  <= icpt_ff;
                  rsp_fit_ff.degenerate <= deg_ff;
                  rsp_fit_ff.pair_count <= PAIR_CNT_W'(job_ff.count);
                  rsp_fit_ff.overflowed <= job_ff.dropped;
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/least_squares_line_fit_top.sv]
// Top level of the least-squares line fit: front end, job queue and solver.
// Pairs are taken one per cycle while req_stall is low; a run's sums are pushed into the job
// queue from register stage s1 with its last pair. The solver runs one fit at a time, with a
// 16-bit chunk multiplier and a one-bit-per-cycle divider.
// Input stalls only while a last pair waits on a full two-entry job queue.
// Synchronous reset clears the accumulators, the queue and any pending result.
`timescale 1ns / 1ps
`default_nettype none

module least_squares_line_fit_top import lsf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  pair_type req_pair,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output fit_type  rsp_fit
);

   logic    push_valid;
   logic    push_ready;
   job_type push_job;
   logic    head_valid;
   logic    pop;
   job_type head_job;

   lsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pair   (req_pair),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   lsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   lsf_solve u_solve (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_fit    (rsp_fit)
   );

endmodule

`default_nettype wire

[rtl/lsf_checker.sv]
// Port-level checks of the least-squares line fit and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lsf_checker import lsf_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_stall,
   input pair_type req_pair,
   input logic     rsp_valid,
   input logic     rsp_stall,
   input fit_type  rsp_fit
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fit))
      else $error("stalled item changed or vanished");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fit.degenerate |-> rsp_fit.slope == '0 && rsp_fit.intercept == '0)
      else $error("degenerate fit with nonzero outputs");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fit.overflowed |-> rsp_fit.pair_count == PAIR_CNT_W'(MAX_SAMPLES))
      else $error("dropped pairs reported below capacity");

   a_fit_needs_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fit.degenerate |-> rsp_fit.pair_count >= PAIR_CNT_W'(2))
      else $error("fit from fewer than two pairs");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item pending after reset");

endmodule

bind least_squares_line_fit_top lsf_checker u_lsf_checker (.*);

`default_nettype wire
